>>> rtl/core/hysteresis_zone_latch_assert.svh
// Assertion macros for the hysteresis zone latch.
// Used by files that check their own logic; expects clk_i and rst_ni in scope.
`ifndef HYSTERESIS_ZONE_LATCH_ASSERT_SVH
`define HYSTERESIS_ZONE_LATCH_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define HZL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define HZL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/hzl_pkg.sv
// Shared types and constants of the hysteresis zone latch.
// No dependencies; imported by hzl_zone_classify and hysteresis_zone_latch.
package hzl_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned TIME_WIDTH      = 63;
  localparam int unsigned SEQ_WIDTH       = 64;
  localparam int unsigned GEN_WIDTH       = 64;
  localparam int unsigned CFG_IDX_WIDTH   = 3;

  localparam logic [1:0] BAND_ENABLE_RST = 2'b11;
  localparam int unsigned BAND_DEG_BIT   = 0;
  localparam int unsigned BAND_CRIT_BIT  = 1;

  typedef enum logic [1:0] {
    ZONE_OK   = 2'd0,
    ZONE_DEG  = 2'd1,
    ZONE_CRIT = 2'd2,
    ZONE_NONE = 2'd3
  } zone_e;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_DIRECTION      = 3'd0,
    CFG_BAND_ENABLE    = 3'd1,
    CFG_DEGRADED_ENTER = 3'd2,
    CFG_DEGRADED_EXIT  = 3'd3,
    CFG_CRITICAL_ENTER = 3'd4,
    CFG_CRITICAL_EXIT  = 3'd5,
    CFG_ESCALATE_AFTER = 3'd6,
    CFG_RECOVER_AFTER  = 3'd7
  } cfg_idx_e;

endpackage

>>> rtl/core/hzl_zone_classify.sv
// Classifies one value against a critical and a degraded bound.
// Depends on hzl_pkg for the zone encoding.
module hzl_zone_classify #(
  parameter int unsigned VALUE_WIDTH = hzl_pkg::VALUE_WIDTH_DEF
) (
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic signed [VALUE_WIDTH-1:0] crit_bound_i,
  input  logic signed [VALUE_WIDTH-1:0] deg_bound_i,
  input  logic                          direction_i,
  input  logic [1:0]                    band_enable_i,
  output hzl_pkg::zone_e                zone_o
);
  import hzl_pkg::*;

  logic crit_worse;
  logic deg_worse;

  // Bound itself counts as the worse side in either direction.
  assign crit_worse = direction_i ? (value_i <= crit_bound_i) : (value_i >= crit_bound_i);
  assign deg_worse  = direction_i ? (value_i <= deg_bound_i)  : (value_i >= deg_bound_i);

  always_comb begin
    if (band_enable_i[BAND_CRIT_BIT] && crit_worse) begin
      zone_o = ZONE_CRIT;
    end else if (band_enable_i[BAND_DEG_BIT] && deg_worse) begin
      zone_o = ZONE_DEG;
    end else begin
      zone_o = ZONE_OK;
    end
  end

endmodule

>>> rtl/core/hysteresis_zone_latch.sv
// Top level of the hysteresis zone latch: configuration registers, input stage,
// zone state and result stage. Depends on hzl_pkg, hzl_zone_classify and the assert header.

// The block takes one telemetry sample per clock while in_stall_o is low and
// returns one result beat per sample, in order. A sample beat is registered at
// acceptance and moves to the result stage when that stage is free or drains;
// the zone, pending count and transition stamps update as it moves. The rate is
// set by the loop through the zone state: classify against the bounds picked by
// the latched zone, step the debounce count and compare it with the limit.
// held_zone, pending_out, change_gen, change_time, seen_time and seen_seq are
// driven straight from the state registers, which hold still while a result beat
// is stalled. The first sample after reset adopts its zone at once and reports
// zone_changed. The user must write configuration through cfg_we_i, cfg_index_i
// and cfg_wdata_i only while no sample is in flight; the block does not enforce it.
`include "hysteresis_zone_latch_assert.svh"

module hysteresis_zone_latch #(
  parameter int unsigned VALUE_WIDTH = hzl_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = hzl_pkg::COUNT_WIDTH_DEF,
  localparam int unsigned CfgWidth = (VALUE_WIDTH > COUNT_WIDTH) ? VALUE_WIDTH : COUNT_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [hzl_pkg::CFG_IDX_WIDTH-1:0]   cfg_index_i,
  input  logic [CfgWidth-1:0]                 cfg_wdata_i,
  // samples
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0]       sample_value_i,
  input  logic [hzl_pkg::TIME_WIDTH-1:0]      sample_time_i,
  input  logic [hzl_pkg::SEQ_WIDTH-1:0]       sample_seq_i,
  input  logic [hzl_pkg::GEN_WIDTH-1:0]       sample_gen_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          held_zone_o,
  output logic [1:0]                          raw_zone_o,
  output logic                                zone_changed_o,
  output logic [COUNT_WIDTH-1:0]              pending_out_o,
  output logic [hzl_pkg::GEN_WIDTH-1:0]       change_gen_o,
  output logic [hzl_pkg::TIME_WIDTH-1:0]      change_time_o,
  output logic [hzl_pkg::TIME_WIDTH-1:0]      seen_time_o,
  output logic [hzl_pkg::SEQ_WIDTH-1:0]       seen_seq_o
);
  import hzl_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] LimitRst = COUNT_WIDTH'(1);

  // Configuration registers.
  logic                          direction_q;
  logic [1:0]                    band_enable_q;
  logic signed [VALUE_WIDTH-1:0] deg_enter_q;
  logic signed [VALUE_WIDTH-1:0] deg_exit_q;
  logic signed [VALUE_WIDTH-1:0] crit_enter_q;
  logic signed [VALUE_WIDTH-1:0] crit_exit_q;
  logic [COUNT_WIDTH-1:0]        escalate_q;
  logic [COUNT_WIDTH-1:0]        recover_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q   <= 1'b0;
      band_enable_q <= BAND_ENABLE_RST;
      deg_enter_q   <= '0;
      deg_exit_q    <= '0;
      crit_enter_q  <= '0;
      crit_exit_q   <= '0;
      escalate_q    <= LimitRst;
      recover_q     <= LimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DIRECTION:      direction_q   <= cfg_wdata_i[0];
        CFG_BAND_ENABLE:    band_enable_q <= cfg_wdata_i[1:0];
        CFG_DEGRADED_ENTER: deg_enter_q   <= cfg_wdata_i[VALUE_WIDTH-1:0];
        CFG_DEGRADED_EXIT:  deg_exit_q    <= cfg_wdata_i[VALUE_WIDTH-1:0];
        CFG_CRITICAL_ENTER: crit_enter_q  <= cfg_wdata_i[VALUE_WIDTH-1:0];
        CFG_CRITICAL_EXIT:  crit_exit_q   <= cfg_wdata_i[VALUE_WIDTH-1:0];
        CFG_ESCALATE_AFTER: escalate_q    <= cfg_wdata_i[COUNT_WIDTH-1:0];
        CFG_RECOVER_AFTER:  recover_q     <= cfg_wdata_i[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input stage moves on whenever the result stage is free or drains.
  logic in_valid_q;
  logic out_valid_q;
  logic advance;
  logic in_accept;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_accept || (in_valid_q && !advance);
      out_valid_q <= advance || (out_valid_q && out_stall_i);
    end
  end

  // Input register.
  logic signed [VALUE_WIDTH-1:0] value_q;
  logic [TIME_WIDTH-1:0]         time_q;
  logic [SEQ_WIDTH-1:0]          seq_q;
  logic [GEN_WIDTH-1:0]          gen_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      value_q <= sample_value_i;
      time_q  <= sample_time_i;
      seq_q   <= sample_seq_i;
      gen_q   <= sample_gen_i;
    end
  end

  // Zone state.
  zone_e                  zone_q, zone_d;
  logic [COUNT_WIDTH-1:0] pending_q, pending_d;
  logic [GEN_WIDTH-1:0]   change_gen_q;
  logic [TIME_WIDTH-1:0]  change_time_q;
  logic [TIME_WIDTH-1:0]  seen_time_q;
  logic [SEQ_WIDTH-1:0]   seen_seq_q;

  logic signed [VALUE_WIDTH-1:0] crit_bound;
  logic signed [VALUE_WIDTH-1:0] deg_bound;
  zone_e                         zone_now;
  zone_e                         zone_raw;

  assign crit_bound = (zone_q == ZONE_CRIT) ? crit_exit_q : crit_enter_q;
  assign deg_bound  = (zone_q == ZONE_DEG)  ? deg_exit_q  : deg_enter_q;

  hzl_zone_classify #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_held_classify (
    .value_i       (value_q),
    .crit_bound_i  (crit_bound),
    .deg_bound_i   (deg_bound),
    .direction_i   (direction_q),
    .band_enable_i (band_enable_q),
    .zone_o        (zone_now)
  );

  hzl_zone_classify #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_raw_classify (
    .value_i       (value_q),
    .crit_bound_i  (crit_enter_q),
    .deg_bound_i   (deg_enter_q),
    .direction_i   (direction_q),
    .band_enable_i (band_enable_q),
    .zone_o        (zone_raw)
  );

  logic [COUNT_WIDTH-1:0] pending_inc;
  logic [COUNT_WIDTH-1:0] limit;
  logic                   changed;

  always_comb begin
    pending_inc = (pending_q == CountMax) ? pending_q : pending_q + COUNT_WIDTH'(1);
    limit       = (logic'(zone_now > zone_q)) ? escalate_q : recover_q;
    if (zone_q == ZONE_NONE) begin
      changed = 1'b1;
    end else if (zone_now == zone_q) begin
      changed = 1'b0;
    end else begin
      changed = (pending_inc >= limit);
    end
    zone_d    = changed ? zone_now : zone_q;
    // A match or a transition clears the count; a differing sample steps it.
    pending_d = (changed || zone_now == zone_q) ? '0 : pending_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q        <= ZONE_NONE;
      pending_q     <= '0;
      change_gen_q  <= '0;
      change_time_q <= '0;
      seen_time_q   <= '0;
      seen_seq_q    <= '0;
    end else if (advance) begin
      zone_q      <= zone_d;
      pending_q   <= pending_d;
      seen_time_q <= time_q;
      seen_seq_q  <= seq_q;
      if (changed) begin
        change_gen_q  <= gen_q;
        change_time_q <= time_q;
      end
    end
  end

  // Result register for the per-beat fields; the rest reads from the state.
  zone_e raw_zone_q;
  logic  changed_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      raw_zone_q <= zone_raw;
      changed_q  <= changed;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign held_zone_o    = zone_q;
  assign raw_zone_o     = raw_zone_q;
  assign zone_changed_o = changed_q;
  assign pending_out_o  = pending_q;
  assign change_gen_o   = change_gen_q;
  assign change_time_o  = change_time_q;
  assign seen_time_o    = seen_time_q;
  assign seen_seq_o     = seen_seq_q;

  `HZL_ASSERT_IMPL(a_change_stamp, out_valid_o && zone_changed_o, change_time_o == seen_time_o, "transition time differs from sample time")
  `HZL_ASSERT_IMPL(a_change_clears, out_valid_o && zone_changed_o, pending_out_o == '0, "pending count not cleared on transition")
  `HZL_ASSERT_IMPL(a_classified, out_valid_o, zone_q != ZONE_NONE, "result offered before any zone was adopted")
  `HZL_ASSERT_IMPL(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "input stalled while result stage is free")
  `HZL_ASSERT_NEXT(a_advance_out, advance, out_valid_o, "advanced beat produced no result")

endmodule
